// File: sv/plin_pkg.sv
// ----------------------------------------------------------------------------
// plin_pkg
// Shared types and codes of the piecewise linear evaluator.
// ----------------------------------------------------------------------------
package plin_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_EVAL  = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_SCALE  = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  localparam logic [31:0] SCALE_RESET  = 32'h0001_0000;
  localparam logic [31:0] OFFSET_RESET = 32'h0000_0000;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_EVAL
  } op_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } job_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

endpackage

// File: sv/plin_front.sv
// ----------------------------------------------------------------------------
// plin_front
// Input stage: takes an item, decodes its command, drops unused codes.
// ----------------------------------------------------------------------------
module plin_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  plin_pkg::in_item_t cmd_item,
  output logic              push_valid,
  input  logic              push_ready,
  output plin_pkg::job_t    push_job
);

  logic               held;
  plin_pkg::in_item_t item;
  logic               drop;
  logic               done;

  always_comb begin
    drop = 1'b0;
    push_job.x = item.x_value;
    push_job.y = item.y_value;
    case (item.command)
      plin_pkg::CMD_CLEAR: push_job.op = plin_pkg::OP_CLEAR;
      plin_pkg::CMD_LOAD:  push_job.op = plin_pkg::OP_LOAD;
      plin_pkg::CMD_EVAL:  push_job.op = plin_pkg::OP_EVAL;
      default: begin
        push_job.op = plin_pkg::OP_CLEAR;
        drop = 1'b1;
      end
    endcase
  end

  assign push_valid = held && !drop;
  assign done       = held && (drop || push_ready);
  assign cmd_stall  = held && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      held <= 1'b1;
      item <= cmd_item;
    end else if (done) begin
      held <= 1'b0;
    end
  end

endmodule

// File: sv/plin_queue.sv
// ----------------------------------------------------------------------------
// plin_queue
// Two-entry job queue between the decode stage and the table engine.
// ----------------------------------------------------------------------------
module plin_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  plin_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output plin_pkg::job_t pop_job
);

  plin_pkg::job_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  logic           pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_job    = slot[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: sv/plin_back.sv
// ----------------------------------------------------------------------------
// plin_back
// Table engine: sorted insert, segment search, serial multiply and divide.
// ----------------------------------------------------------------------------
module plin_back #(
  parameter int MAX_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  plin_pkg::job_t     pop_job,
  input  logic [31:0]        scale,
  input  logic [31:0]        offset,
  output logic               res_valid,
  input  logic               res_stall,
  output plin_pkg::out_item_t res_item
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_RD,
    S_LOAD_CHK,
    S_LOAD_WR,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_MUL,
    S_DIV_INIT,
    S_DIV,
    S_FIN_LIN,
    S_FIN_INT,
    S_OUT
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [IW-1:0]       pos;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       rd_addr;
  plin_pkg::point_t    mem [MAX_POINTS];
  plin_pkg::point_t    rd;
  plin_pkg::point_t    prev;
  plin_pkg::point_t    wdata;
  logic                mem_we;
  logic signed [31:0]  x_in;
  logic signed [31:0]  y_in;
  logic [32:0]         mul_a;
  logic [32:0]         mul_b;
  logic [63:0]         acc;
  logic [31:0]         rem;
  logic [31:0]         lo;
  logic [31:0]         w;
  logic [5:0]          step;
  logic                neg;
  logic                lin;
  logic signed [31:0]  y1;
  logic [31:0]         res_val;
  logic                res_sat;

  logic signed [32:0]  diff;
  logic [32:0]         diff_mag;
  logic [31:0]         scale_mag;
  logic signed [32:0]  dy;
  logic [32:0]         div_t;
  logic [32:0]         div_sub;
  logic                div_ge;
  logic [63:0]         rnd;
  logic                sat_pos;
  logic                sat_neg;
  logic                take;

  assign pop_ready = (state == S_IDLE);
  assign take      = pop_valid && pop_ready;

  always_comb begin
    diff      = {pop_job.x[31], pop_job.x} - {offset[31], offset};
    diff_mag  = diff[32] ? 33'(-diff) : 33'(diff);
    scale_mag = scale[31] ? (~scale + 32'd1) : scale;
    dy        = {rd.y[31], rd.y} - {prev.y[31], prev.y};
    div_t     = {rem, lo[31]};
    div_sub   = div_t - {1'b0, w};
    div_ge    = !div_sub[32];
    // negative products round toward minus infinity
    rnd       = acc + 64'h0000_0000_0000_FFFF;
    sat_pos   = (acc[63:47] != 17'd0);
    sat_neg   = (rnd[63:48] != 16'd0) || (rnd[47] && (rnd[46:16] != 31'd0));
  end

  always_comb begin
    mem_we = (state == S_LOAD_WR) || ((state == S_LOAD_CHK) && (rd.x > x_in));
    wdata  = rd;
    if (state == S_LOAD_WR) begin
      wdata.x = x_in;
      wdata.y = y_in;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos] <= wdata;
    end
    rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            x_in <= pop_job.x;
            y_in <= pop_job.y;
            case (pop_job.op)
              plin_pkg::OP_CLEAR: count <= '0;
              plin_pkg::OP_LOAD: begin
                if (count == CW'(MAX_POINTS)) begin
                  state <= S_IDLE;
                end else if (count == '0) begin
                  pos   <= '0;
                  state <= S_LOAD_WR;
                end else begin
                  pos     <= IW'(count);
                  rd_addr <= IW'(count - CW'(1));
                  state   <= S_LOAD_RD;
                end
              end
              plin_pkg::OP_EVAL: begin
                if (count == '0) begin
                  mul_a <= diff_mag;
                  mul_b <= {1'b0, scale_mag};
                  neg   <= diff[32] ^ scale[31];
                  lin   <= 1'b1;
                  acc   <= '0;
                  step  <= '0;
                  state <= S_MUL;
                end else begin
                  idx     <= '0;
                  rd_addr <= '0;
                  state   <= S_SRCH_RD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LOAD_RD: state <= S_LOAD_CHK;
        S_LOAD_CHK: begin
          if (rd.x > x_in) begin
            // entry moved up one slot this cycle
            pos <= pos - IW'(1);
            if (pos == IW'(1)) begin
              state <= S_LOAD_WR;
            end else begin
              rd_addr <= pos - IW'(2);
              state   <= S_LOAD_RD;
            end
          end else begin
            state <= S_LOAD_WR;
          end
        end
        S_LOAD_WR: begin
          count <= count + CW'(1);
          state <= S_IDLE;
        end
        S_SRCH_RD: state <= S_SRCH_CHK;
        S_SRCH_CHK: begin
          if (count == CW'(1)) begin
            res_val <= rd.y;
            res_sat <= 1'b0;
            state   <= S_OUT;
          end else if (rd.x < x_in) begin
            prev <= rd;
            if ((CW'(idx) + CW'(1)) == count) begin
              res_val <= rd.y;
              res_sat <= 1'b0;
              state   <= S_OUT;
            end else begin
              idx     <= idx + IW'(1);
              rd_addr <= idx + IW'(1);
              state   <= S_SRCH_RD;
            end
          end else if (idx == '0) begin
            res_val <= rd.y;
            res_sat <= 1'b0;
            state   <= S_OUT;
          end else if (rd.x <= prev.x) begin
            res_val <= prev.y;
            res_sat <= 1'b0;
            state   <= S_OUT;
          end else begin
            w     <= rd.x - prev.x;
            mul_a <= {1'b0, x_in - prev.x};
            mul_b <= dy[32] ? 33'(-dy) : 33'(dy);
            neg   <= dy[32];
            y1    <= prev.y;
            lin   <= 1'b0;
            acc   <= '0;
            step  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // MSB-first shift and add
          acc   <= {acc[62:0], 1'b0} + (mul_b[32] ? {31'd0, mul_a} : 64'd0);
          mul_b <= {mul_b[31:0], 1'b0};
          step  <= step + 6'd1;
          if (step == 6'd32) begin
            state <= lin ? S_FIN_LIN : S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          // product < w * 2^32, so the quotient fits 32 bits
          rem   <= acc[63:32];
          lo    <= acc[31:0];
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= div_ge ? div_sub[31:0] : div_t[31:0];
          lo   <= {lo[30:0], div_ge};
          step <= step + 6'd1;
          if (step == 6'd31) begin
            state <= S_FIN_INT;
          end
        end
        S_FIN_LIN: begin
          if (!neg) begin
            res_val <= sat_pos ? 32'h7FFF_FFFF : acc[47:16];
            res_sat <= sat_pos;
          end else begin
            res_val <= sat_neg ? 32'h8000_0000 : (~rnd[47:16] + 32'd1);
            res_sat <= sat_neg;
          end
          state <= S_OUT;
        end
        S_FIN_INT: begin
          res_val <= neg ? (y1 - lo) : (y1 + lo);
          res_sat <= 1'b0;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid || !res_stall) begin
            res_valid             <= 1'b1;
            res_item.result_value <= res_val;
            res_item.saturated    <= res_sat;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count above table size");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_LOAD_CHK || state == S_LOAD_WR))
    else $error("table written outside a load");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (take && pop_job.op == plin_pkg::OP_CLEAR) |=> (count == '0))
    else $error("clear did not empty the table");

  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_OUT))
    else $error("result raised outside output state");

  a_full_load: assert property (@(posedge clk) disable iff (rst)
    (take && pop_job.op == plin_pkg::OP_LOAD && count == CW'(MAX_POINTS))
      |=> (state == S_IDLE && count == CW'(MAX_POINTS)))
    else $error("load into full table changed state");

endmodule

// File: sv/piecewise_linear_evaluator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_evaluator
// Q16.16 piecewise linear function over a sorted breakpoint table.
// ----------------------------------------------------------------------------
// Items enter a decode stage and a two-entry queue, then run one at a time in
// the table engine. A clear only resets the point count; a load reads and
// compares entries from the top of the table down, moving each larger one up
// a slot, then writes the new point. An evaluate scans the table one
// breakpoint at a time (single-port table read); on interpolation it then runs
// a shift-add multiplier and a restoring divider, while the empty-table
// transform runs the multiplier only. A finished result sits in an output
// register while the next item runs.
// ----------------------------------------------------------------------------
module piecewise_linear_evaluator #(
  parameter int MAX_POINTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  plin_pkg::in_item_t  cmd_item,
  output logic                res_valid,
  input  logic                res_stall,
  output plin_pkg::out_item_t res_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic           push_valid;
  logic           push_ready;
  plin_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  plin_pkg::job_t pop_job;
  logic [31:0]    scale;
  logic [31:0]    offset;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale  <= plin_pkg::SCALE_RESET;
      offset <= plin_pkg::OFFSET_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        plin_pkg::REG_SCALE:  scale  <= pwdata;
        plin_pkg::REG_OFFSET: offset <= pwdata;
        default: scale <= scale;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      plin_pkg::REG_SCALE:  prdata = scale;
      plin_pkg::REG_OFFSET: prdata = offset;
      default: prdata = 32'd0;
    endcase
  end

  plin_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job)
  );

  plin_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job)
  );

  plin_back #(
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_job  (pop_job),
    .scale    (scale),
    .offset   (offset),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item)
  );

endmodule

// File: bench/piecewise_linear_evaluator_tb.sv
// ----------------------------------------------------------------------------
// piecewise_linear_evaluator_tb
// Self-checking bench: breakpoint table loads, clears and evaluates, with
// random idle on both sides, checked against an in-bench Q16.16 predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module piecewise_linear_evaluator_tb;

  localparam int NPTS        = 16;
  localparam int IDLE_PCT    = 22;
  localparam int WD_LIMIT    = 20000;
  localparam int TAIL_WAIT   = 300;
  localparam int HOLD_CYCLES = 800;
  localparam logic [1:0] CMD_NOP = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  plin_pkg::in_item_t  cmd_item = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  plin_pkg::out_item_t res_item;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  piecewise_linear_evaluator #(.MAX_POINTS(NPTS)) uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_item(cmd_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // predictor state
  logic signed [31:0] tbl_x [NPTS];
  logic signed [31:0] tbl_y [NPTS];
  int                 tbl_n = 0;
  logic signed [31:0] gain = 32'sh0001_0000;
  logic signed [31:0] bias = 32'sh0;

  plin_pkg::in_item_t  pending_cmds [$];
  plin_pkg::out_item_t expected_results [$];
  int  errors = 0;
  int  n_eval = 0, n_sat = 0, n_interp = 0;

  bit quiet_tx = 1'b0;   // no random idle on sender
  bit quiet_rx = 1'b0;
  bit hold_req = 1'b0;   // ask the receiver for one long hold-off
  bit hold_ack = 1'b0;
  int hold_left = 0;
  bit pause_tx = 1'b0;   // sender pauses
  int idle_cycles = 0;
  int accepted = 0;

  function automatic plin_pkg::out_item_t predict_linear(logic signed [31:0] xv);
    plin_pkg::out_item_t r;
    logic signed [63:0]  diff;
    logic signed [127:0] prod;
    logic signed [127:0] q;
    diff = 64'(xv) - 64'(bias);
    prod = 128'(diff) * 128'(gain);
    q = prod >>> 16;
    r.saturated = 1'b0;
    if (q > 128'sd2147483647) begin
      q = 128'sd2147483647;
      r.saturated = 1'b1;
    end else if (q < -128'sd2147483648) begin
      q = -128'sd2147483648;
      r.saturated = 1'b1;
    end
    r.result_value = q[31:0];
    return r;
  endfunction

  function automatic plin_pkg::out_item_t predict_eval(logic signed [31:0] xv);
    plin_pkg::out_item_t r;
    int i;
    logic signed [63:0]  w, dx, dy, ady, qv;
    r.saturated = 1'b0;
    if (tbl_n == 0) return predict_linear(xv);
    i = 0;
    while (i < tbl_n && tbl_x[i] < xv) i++;
    if (tbl_n == 1) r.result_value = tbl_y[0];
    else if (i >= tbl_n) r.result_value = tbl_y[tbl_n-1];
    else if (i == 0) r.result_value = tbl_y[0];
    else if (tbl_x[i] <= tbl_x[i-1]) r.result_value = tbl_y[i-1];
    else begin
      w = 64'(tbl_x[i]) - 64'(tbl_x[i-1]);
      dx = 64'(xv) - 64'(tbl_x[i-1]);
      dy = 64'(tbl_y[i]) - 64'(tbl_y[i-1]);
      ady = dy < 0 ? -dy : dy;
      // product can exceed 2^63, so divide unsigned
      qv = 64'($unsigned(dx) * $unsigned(ady) / $unsigned(w));
      r.result_value = dy < 0 ? 32'(64'(tbl_y[i-1]) - qv) : 32'(64'(tbl_y[i-1]) + qv);
    end
    return r;
  endfunction

  task automatic apply_item(plin_pkg::in_item_t it);
    int pos;
    case (it.command)
      plin_pkg::CMD_CLEAR: tbl_n = 0;
      plin_pkg::CMD_LOAD: begin
        if (tbl_n < NPTS) begin
          pos = tbl_n;
          while (pos > 0 && tbl_x[pos-1] > it.x_value) begin
            tbl_x[pos] = tbl_x[pos-1];
            tbl_y[pos] = tbl_y[pos-1];
            pos--;
          end
          tbl_x[pos] = it.x_value;
          tbl_y[pos] = it.y_value;
          tbl_n++;
        end
      end
      plin_pkg::CMD_EVAL: begin
        plin_pkg::out_item_t r;
        r = predict_eval(it.x_value);
        if (r.saturated) n_sat++;
        if (tbl_n > 1) n_interp++;
        n_eval++;
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  logic take_cmd;
  assign take_cmd = cmd_valid && !cmd_stall;

  // accept bookkeeping happens at posedge, payload changes at negedge
  bit cmd_done;
  always @(posedge clk) begin
    cmd_done <= !rst && take_cmd;
    if (!rst && take_cmd) begin
      apply_item(cmd_item);
      accepted++;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_done) begin
      if (pending_cmds.size() > 0 && !pause_tx &&
          (quiet_tx || $urandom_range(99) >= IDLE_PCT)) begin
        cmd_item  <= pending_cmds.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off counted here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_ack) begin
      res_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_ack  <= 1'b1;
    end else begin
      res_stall <= !quiet_rx && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      plin_pkg::out_item_t e;
      if (expected_results.size() == 0) begin
        $error("result with none expected: result_value %h", res_item.result_value);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (res_item.result_value !== e.result_value) begin
          $error("result_value expected %h actual %h", e.result_value,
                 res_item.result_value);
          errors++;
        end
        if (res_item.saturated !== e.saturated) begin
          $error("saturated expected %b actual %b", e.saturated, res_item.saturated);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no acceptance on either side
  always @(posedge clk) begin
    if (rst || take_cmd || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic reg_write(logic idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == plin_pkg::REG_SCALE) gain = v; else bias = v;
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || cmd_valid || expected_results.size() > 0)
      @(posedge clk);
    // a trailing load/clear may still be running
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  function automatic plin_pkg::in_item_t mk(logic [1:0] c, logic [31:0] xv,
                                            logic [31:0] yv);
    plin_pkg::in_item_t it;
    it.command = c; it.x_value = xv; it.y_value = yv;
    return it;
  endfunction

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  // a table of random size then evaluations across and beyond it
  task automatic queue_table_set();
    int np, ne;
    np = $urandom_range(9) == 0 ? NPTS + 2 : $urandom_range(1, 6);
    pending_cmds.push_back(mk(plin_pkg::CMD_CLEAR, $urandom, $urandom));
    for (int k = 0; k < np; k++)
      pending_cmds.push_back(mk(plin_pkg::CMD_LOAD, rnd_val(), rnd_val()));
    ne = $urandom_range(2, 8);
    for (int k = 0; k < ne; k++)
      pending_cmds.push_back(mk(plin_pkg::CMD_EVAL, rnd_val(), $urandom));
    if ($urandom_range(9) == 0) pending_cmds.push_back(mk(CMD_NOP, $urandom, $urandom));
  endtask

  initial begin
    int total;
    logic [31:0] gains [5];
    logic [31:0] biases [5];
    gains  = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'h0000_8000};
    biases = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0003_0000, 32'hFFFF_FFFF};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty-table transform at reset settings, edges, special cases
    quiet_tx = 1'b1;
    pending_cmds.push_back(mk(plin_pkg::CMD_EVAL, 32'h7FFF_FFFF, 0));
    pending_cmds.push_back(mk(plin_pkg::CMD_EVAL, 32'h8000_0000, 0));
    pending_cmds.push_back(mk(plin_pkg::CMD_EVAL, 32'hFFFF_FFFF, 0));
    pending_cmds.push_back(mk(CMD_NOP, 32'h1234, 32'h5678));
    pending_cmds.push_back(mk(plin_pkg::CMD_LOAD, 32'h0005_0000, 32'h7FFF_FFFF));
    pending_cmds.push_back(mk(plin_pkg::CMD_EVAL, 32'h8000_0000, 0));    // one point
    pending_cmds.push_back(mk(plin_pkg::CMD_LOAD, 32'h0001_0000, 32'h8000_0000));
    pending_cmds.push_back(mk(plin_pkg::CMD_LOAD, 32'h0005_0000, 32'h0)); // equal x
    pending_cmds.push_back(mk(plin_pkg::CMD_EVAL, 32'h8000_0000, 0));    // below first
    pending_cmds.push_back(mk(plin_pkg::CMD_EVAL, 32'h0001_0000, 0));
    pending_cmds.push_back(mk(plin_pkg::CMD_EVAL, 32'h0003_0001, 0));    // interpolate
    pending_cmds.push_back(mk(plin_pkg::CMD_EVAL, 32'h0005_0000, 0));
    pending_cmds.push_back(mk(plin_pkg::CMD_EVAL, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    for (int k = 0; k < NPTS; k++)                                       // fill, overflow
      pending_cmds.push_back(mk(plin_pkg::CMD_LOAD, 32'h8000_0000 + k * 32'h1000_0000, k));
    pending_cmds.push_back(mk(plin_pkg::CMD_EVAL, 32'h0, 0));
    pending_cmds.push_back(mk(plin_pkg::CMD_CLEAR, 0, 0));
    pending_cmds.push_back(mk(plin_pkg::CMD_EVAL, 32'h0002_0000, 0));
    drain();
    quiet_tx = 1'b0;

    total = 0;
    for (int ph = 0; ph < 5; ph++) begin
      reg_write(plin_pkg::REG_SCALE, ph == 4 ? $urandom : gains[ph]);
      reg_write(plin_pkg::REG_OFFSET, ph == 4 ? $urandom : biases[ph]);
      if (ph == 1) begin
        quiet_rx = 1'b1;
        quiet_tx = 1'b1;
      end
      if (ph == 2) begin
        quiet_rx = 1'b0;
        quiet_tx = 1'b0;
      end
      while (total < (ph + 1) * 150) begin
        int before_sz;
        before_sz = pending_cmds.size();
        queue_table_set();
        total += pending_cmds.size() - before_sz;
      end
      if (ph == 2) begin
        // receiver holds off while sender keeps offering
        hold_req = 1'b1;
        wait (hold_ack && hold_left == 0);
        hold_req = 1'b0;
      end
      if (ph == 3) begin
        while (pending_cmds.size() > 60) @(posedge clk);
        pause_tx = 1'b1;
        while (cmd_valid || expected_results.size() > 0) @(posedge clk);
        pause_tx = 1'b0;
      end
      drain();
    end

    $display("covered %0d items, %0d evaluations (%0d on tables of 2+, %0d saturated)",
             accepted, n_eval, n_interp, n_sat);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
sv/plin_pkg.sv
sv/plin_front.sv
sv/plin_queue.sv
sv/plin_back.sv
sv/piecewise_linear_evaluator.sv
bench/piecewise_linear_evaluator_tb.sv
